@@ hdl/lcnc_pkg.sv @@
// Shared types, constants and helper functions for the Luhn card number classifier.
// No dependencies; imported by lcnc_ctrl, lcnc_dp and luhn_card_number_classifier.
`default_nettype none

package lcnc_pkg;

    // Field widths
    localparam int CARD_W    = 63;
    localparam int CLASS_W   = 2;
    localparam int COUNT_W   = 5;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W     = NUM_DIGITS * 4;
    localparam int BIT_CNT_W = 6;

    // Last index of the bit loop and of the digit loop
    localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(CARD_W - 1);
    localparam logic [COUNT_W-1:0]   DIGIT_LAST = COUNT_W'(NUM_DIGITS - 1);

    // Card classes
    localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_VISA    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_AMEX    = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_MASTER  = 2'd3;

    // Lengths and leading digits that select a class
    localparam logic [COUNT_W-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_AMEX       = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_LONG       = 5'd16;
    localparam logic [3:0] LEAD_VISA   = 4'd4;
    localparam logic [3:0] LEAD_AMEX   = 4'd3;
    localparam logic [3:0] LEAD_MASTER = 4'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                load;     // capture a new card number
        logic                dabble;   // one binary-to-BCD shift step
        logic                scan;     // consume one BCD digit
        logic                publish;  // move results to the output register
        logic [COUNT_W-1:0]  digit_idx;
    } lcnc_cmd_t;

    // Doubled Luhn digit: 2d, minus 9 when above 9
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] dd;
        begin
            dd = {d, 1'b0};
            if (dd > 5'd9)
                luhn_double = 4'(dd - 5'd9);
            else
                luhn_double = dd[3:0];
        end
    endfunction

    // Add a digit value to a running sum modulo ten
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 5'd10)
                add_mod10 = 4'(s - 5'd10);
            else
                add_mod10 = s[3:0];
        end
    endfunction

    // Class from length and the two leading digits (checksum applied by caller)
    function automatic logic [CLASS_W-1:0] classify(
        input logic [COUNT_W-1:0] count,
        input logic [3:0]         lead1,
        input logic [3:0]         lead2
    );
        begin
            classify = CLASS_INVALID;
            if (count == LEN_VISA_SHORT) begin
                if (lead1 == LEAD_VISA)
                    classify = CLASS_VISA;
            end else if (count == LEN_AMEX) begin
                if (lead1 == LEAD_AMEX && (lead2 == 4'd4 || lead2 == 4'd7))
                    classify = CLASS_AMEX;
            end else if (count == LEN_LONG) begin
                if (lead1 == LEAD_MASTER && lead2 >= 4'd1 && lead2 <= 4'd5)
                    classify = CLASS_MASTER;
                else if (lead1 == LEAD_VISA)
                    classify = CLASS_VISA;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/lcnc_ctrl.sv @@
// Controller for the Luhn card number classifier: sequences load, BCD conversion,
// digit scan and result hand-off. Depends on lcnc_pkg.
`default_nettype none

module lcnc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lcnc_pkg::lcnc_cmd_t   cmd
);
    import lcnc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next-state and command decode
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.digit_idx  = dig_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST) begin
                    dig_cnt_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan     = 1'b1;
                dig_cnt_next = dig_cnt_reg + 1'b1;
                if (dig_cnt_reg == DIGIT_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready) begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcnc_dp.sv @@
// Datapath for the Luhn card number classifier: double-dabble BCD converter,
// serial digit scanner (Luhn sum, length, leading digits) and output register.
// Depends on lcnc_pkg.
`default_nettype none

module lcnc_dp (
    input  wire logic                          clk,
    input  wire lcnc_pkg::lcnc_cmd_t           cmd,
    input  wire logic [lcnc_pkg::CARD_W-1:0]   card_number,
    output logic      [lcnc_pkg::CLASS_W-1:0]  card_class,
    output logic                               checksum_ok,
    output logic      [lcnc_pkg::COUNT_W-1:0]  digit_count
);
    import lcnc_pkg::*;

    logic [CARD_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         lead1_reg, lead1_next;
    logic [3:0]         lead2_reg, lead2_next;
    logic [3:0]         prev_reg, prev_next;
    logic [3:0]         digit;
    logic [3:0]         weighted;
    logic [CLASS_W-1:0] class_reg;
    logic               ok_reg;
    logic [COUNT_W-1:0] count_out_reg;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // Digit scan: lowest BCD digit, doubled on odd positions
    assign digit    = bcd_reg[3:0];
    assign weighted = cmd.digit_idx[0] ? luhn_double(digit) : digit;

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        lead1_next = lead1_reg;
        lead2_next = lead2_reg;
        prev_next  = prev_reg;
        if (cmd.load) begin
            bin_next   = card_number;
            bcd_next   = '0;
            sum_next   = '0;
            count_next = '0;
            lead1_next = '0;
            lead2_next = '0;
            prev_next  = '0;
        end else if (cmd.dabble) begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[CARD_W-1]};
            bin_next = {bin_reg[CARD_W-2:0], 1'b0};
        end else if (cmd.scan) begin
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
            sum_next = add_mod10(sum_reg, weighted);
            prev_next = digit;
            // highest nonzero digit so far sets length and leading pair
            if (digit != 4'd0) begin
                count_next = cmd.digit_idx + 1'b1;
                lead1_next = digit;
                lead2_next = prev_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        lead1_reg <= lead1_next;
        lead2_reg <= lead2_next;
        prev_reg  <= prev_next;
    end

    // Output register, loaded on publish
    always_ff @(posedge clk)
    begin
        if (cmd.publish) begin
            ok_reg        <= (sum_reg == 4'd0);
            count_out_reg <= count_reg;
            class_reg     <= (sum_reg == 4'd0)
                             ? classify(count_reg, lead1_reg, lead2_reg)
                             : CLASS_INVALID;
        end
    end

    assign card_class  = class_reg;
    assign checksum_ok = ok_reg;
    assign digit_count = count_out_reg;

endmodule

`default_nettype wire

@@ hdl/luhn_card_number_classifier.sv @@
// Top level of the Luhn card number classifier: controller plus datapath.
// Depends on lcnc_pkg, lcnc_ctrl and lcnc_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | card_number[62:0]
//   output   | out_valid / out_ready| card_class[1:0], checksum_ok, digit_count[4:0]
//
// The card is loaded on its accepting edge; the engine then runs 63 double-dabble
// shift steps (one per input bit), 19 digit-scan steps (one per BCD digit) and one
// publish step that sets out_valid. A new card is not taken until publish is done.
// in_ready is high only while the engine is idle; a finished result waits
// in the output register, so the next card is accepted while it is still pending.
// A stalled output holds the engine in its last step until the register frees.
// Reset clears the controller only; no clearing pass is needed.
`default_nettype none

module luhn_card_number_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lcnc_pkg::CARD_W-1:0]   card_number,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [lcnc_pkg::CLASS_W-1:0]  card_class,
    output logic                               checksum_ok,
    output logic      [lcnc_pkg::COUNT_W-1:0]  digit_count
);
    import lcnc_pkg::*;

    lcnc_cmd_t cmd;

    // Sequencer
    lcnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Conversion, scan and result registers
    lcnc_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .card_number (card_number),
        .card_class  (card_class),
        .checksum_ok (checksum_ok),
        .digit_count (digit_count)
    );

endmodule

`default_nettype wire
